### rtl/core/pes2x_pkg.sv
// Shared types and constants for the 2x edge-directed pixel scaler.
package pes2x_pkg;

   // Pixel width used for compares and outputs
   localparam int unsigned PIXEL_BITS = 32;

   typedef logic [PIXEL_BITS-1:0] pixel_type;

   // One source column as taken from the request channel
   typedef struct packed {
      pixel_type above;
      pixel_type centre;
      pixel_type below;
      logic      line_end;
   } column_type;

   // Five-pixel neighbourhood of the column being emitted
   typedef struct packed {
      pixel_type left;
      pixel_type top;
      pixel_type mid;
      pixel_type bottom;
      pixel_type right;
      logic      done;
   } nbhd_type;

   // One 2x2 output block
   typedef struct packed {
      pixel_type upper_left;
      pixel_type upper_right;
      pixel_type lower_left;
      pixel_type lower_right;
      logic      row_done;
   } result_type;

   // Handshake between the column window and the output register
   typedef struct packed {
      logic emit;
      logic step;
   } win_ctrl_type;

endpackage

### rtl/core/pes2x_corner.sv
// Corner selection: the four equality-test muxes of one 2x2 output block.
module pes2x_corner (
   input  pes2x_pkg::nbhd_type   nbhd,
   input  logic                  double_width,
   output pes2x_pkg::result_type result
);

   logic sel_ul;
   logic sel_ur;
   logic sel_ll;
   logic sel_lr;

   // Test each corner against its edge pixel
   assign sel_ul = (nbhd.left == nbhd.top) && (nbhd.right != nbhd.top)
                   && (nbhd.bottom != nbhd.top);
   assign sel_ur = (nbhd.right == nbhd.top) && (nbhd.left != nbhd.top)
                   && (nbhd.bottom != nbhd.top);
   assign sel_ll = (nbhd.left == nbhd.bottom) && (nbhd.right != nbhd.bottom)
                   && (nbhd.top != nbhd.bottom);
   assign sel_lr = (nbhd.right == nbhd.bottom) && (nbhd.left != nbhd.bottom)
                   && (nbhd.top != nbhd.bottom);

   // Pick edge or centre pixel; drop the right column in single width
   always_comb begin
      result.upper_left  = sel_ul ? nbhd.top : nbhd.mid;
      result.lower_left  = sel_ll ? nbhd.bottom : nbhd.mid;
      result.upper_right = '0;
      result.lower_right = '0;
      if (double_width) begin
         result.upper_right = sel_ur ? nbhd.top : nbhd.mid;
         result.lower_right = sel_lr ? nbhd.bottom : nbhd.mid;
      end
      result.row_done = nbhd.done;
   end

endmodule

### rtl/core/pes2x_window.sv
// Column input register and three-column window with emit sequencing.
module pes2x_window (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    col_valid,
   output logic                    col_ready,
   input  pes2x_pkg::column_type   col,
   input  logic                    out_free,
   output pes2x_pkg::win_ctrl_type ctrl,
   output pes2x_pkg::nbhd_type     nbhd
);

   logic                  in_valid_ff, in_valid_in;
   pes2x_pkg::column_type item_ff;
   logic                  pending_ff, pending_in;
   logic                  phase_ff, phase_in;
   pes2x_pkg::pixel_type  left_ff, left_in;
   pes2x_pkg::column_type held_ff, held_in;
   logic                  need_out;
   logic                  consume;

   // Decide whether the registered column steps this cycle
   always_comb begin
      need_out  = pending_ff || item_ff.line_end;
      ctrl.step = in_valid_ff && (!need_out || out_free);
      ctrl.emit = ctrl.step && need_out;
      // A line end behind a held column needs a second step
      consume   = ctrl.step && !(pending_ff && item_ff.line_end);
      col_ready = !in_valid_ff || consume;
   end

   // Build the neighbourhood of the column to emit
   always_comb begin
      if (pending_ff) begin
         nbhd.left   = left_ff;
         nbhd.top    = held_ff.above;
         nbhd.mid    = held_ff.centre;
         nbhd.bottom = held_ff.below;
         nbhd.right  = item_ff.centre;
         nbhd.done   = 1'b0;
      end else begin
         nbhd.left   = phase_ff ? left_ff : item_ff.centre;
         nbhd.top    = item_ff.above;
         nbhd.mid    = item_ff.centre;
         nbhd.bottom = item_ff.below;
         nbhd.right  = item_ff.centre;
         nbhd.done   = 1'b1;
      end
   end

   // Advance the window on each step
   always_comb begin
      pending_in = pending_ff;
      phase_in   = phase_ff;
      left_in    = left_ff;
      held_in    = held_ff;
      if (ctrl.step) begin
         if (pending_ff) begin
            left_in = held_ff.centre;
            if (item_ff.line_end) begin
               pending_in = 1'b0;
               phase_in   = 1'b1;
            end else begin
               held_in = item_ff;
            end
         end else begin
            phase_in = 1'b0;
            if (!item_ff.line_end) begin
               left_in    = item_ff.centre;
               held_in    = item_ff;
               pending_in = 1'b1;
            end
         end
      end
   end

   // Hold or refill the input register
   always_comb begin
      in_valid_in = in_valid_ff;
      if (col_valid && col_ready) begin
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pending_ff  <= 1'b0;
         phase_ff    <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         pending_ff  <= pending_in;
         phase_ff    <= phase_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (col_valid && col_ready) begin
         item_ff <= col;
      end
      left_ff <= left_in;
      held_ff <= held_in;
   end

endmodule

### rtl/core/pixel_art_edge_scaler_2x_top.sv
// Top level of the 2x edge-directed pixel scaler: CSR, window and result register.
//
// Usage: each request transfer carries one source column (above, centre and
// below pixel, plus line_end on the last column of a line). Each response
// transfer carries one 2x2 output block; row_done marks the block of the last
// column. The block of a column is produced when its right neighbour arrives,
// so a line of N columns gives N responses: none for the first column, one
// for each later one, and two for the column that ends a line (one if the
// line is a single column wide).
// A response comes from the result register, loaded from the column in the input
// register once its neighbourhood is complete; a line-end column's own block
// follows the block before it. Throughput: one column per cycle unless the
// receiver stalls, set by the single input register feeding the corner compares;
// a line-end column behind a held one stays there until the held block is emitted.
// The csr channel writes double_width (reset 1); 0 zeroes the right pixels.
// It is always ready and should be written only while the block is idle.
// Reset is synchronous: the window empties and both channels go idle.
// When the receiver stalls, the result register holds its block; columns that
// need no result still advance, others wait and request ready drops.
module pixel_art_edge_scaler_2x_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic                        csr_double_width,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [31:0]                 req_above_pixel,
   input  logic [31:0]                 req_centre_pixel,
   input  logic [31:0]                 req_below_pixel,
   input  logic                        req_line_end,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [31:0]                 rsp_upper_left,
   output logic [31:0]                 rsp_upper_right,
   output logic [31:0]                 rsp_lower_left,
   output logic [31:0]                 rsp_lower_right,
   output logic                        rsp_row_done
);

   logic                    double_width_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   pes2x_pkg::result_type   result_ff;
   pes2x_pkg::result_type   result;
   pes2x_pkg::column_type   col;
   pes2x_pkg::nbhd_type     nbhd;
   pes2x_pkg::win_ctrl_type ctrl;
   logic                    out_free;

   // Configuration register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         double_width_ff <= 1'b1;
      end else if (csr_valid) begin
         double_width_ff <= csr_double_width;
      end
   end

   // Pack the request column
   always_comb begin
      col.above    = req_above_pixel;
      col.centre   = req_centre_pixel;
      col.below    = req_below_pixel;
      col.line_end = req_line_end;
   end

   pes2x_window u_window (
      .clock     (clock),
      .reset     (reset),
      .col_valid (req_valid),
      .col_ready (req_ready),
      .col       (col),
      .out_free  (out_free),
      .ctrl      (ctrl),
      .nbhd      (nbhd)
   );

   pes2x_corner u_corner (
      .nbhd         (nbhd),
      .double_width (double_width_ff),
      .result       (result)
   );

   // Result register: load on emit, hold while the receiver stalls
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = ctrl.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit && out_free) begin
         result_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_upper_left  = result_ff.upper_left;
   assign rsp_upper_right = result_ff.upper_right;
   assign rsp_lower_left  = result_ff.lower_left;
   assign rsp_lower_right = result_ff.lower_right;
   assign rsp_row_done    = result_ff.row_done;

endmodule

### tb/sv/pixel_art_edge_scaler_2x_top_tb.sv
// Self-checking testbench for the 2x edge-directed pixel scaler top level.
module pixel_art_edge_scaler_2x_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pes2x_pkg::*;

   localparam int unsigned DRAIN_CYCLES   = 10;
   localparam int unsigned SETTLE_CYCLES  = 8;
   localparam int unsigned PRINT_LIMIT    = 20;
   localparam int unsigned PHASE_COLUMNS  = 330;

   // Clock, reset and block ports
   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        csr_valid         = 1'b0;
   logic        csr_ready;
   logic        csr_double_width  = 1'b0;
   logic        req_valid         = 1'b0;
   logic        req_ready;
   logic [31:0] req_above_pixel   = '0;
   logic [31:0] req_centre_pixel  = '0;
   logic [31:0] req_below_pixel   = '0;
   logic        req_line_end      = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready         = 1'b0;
   logic [31:0] rsp_upper_left;
   logic [31:0] rsp_upper_right;
   logic [31:0] rsp_lower_left;
   logic [31:0] rsp_lower_right;
   logic        rsp_row_done;

   // Columns waiting for the driver and blocks waiting for the block
   column_type pending_columns[$];
   result_type expected_blocks[$];

   // Transfer flags seen at the last rising edge
   logic req_taken = 1'b0;
   logic csr_taken = 1'b0;

   // Scaler window as predicted by the testbench
   pixel_type win_left   = '0;
   pixel_type win_above  = '0;
   pixel_type win_centre = '0;
   pixel_type win_below  = '0;
   logic      win_held   = 1'b0;
   logic      width_mode = 1'b1;

   int unsigned mismatch_count = 0;
   int unsigned columns_sent   = 0;
   int unsigned blocks_checked = 0;
   int unsigned lines_sent     = 0;
   int unsigned csr_writes     = 0;

   // Sender and receiver pacing
   int unsigned burst_left   = 0;
   int unsigned gap_left     = 0;
   int unsigned stall_mode   = 0;
   int unsigned pattern_left = 0;
   int unsigned stall_tick   = 0;

   pixel_art_edge_scaler_2x_top dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_double_width (csr_double_width),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_above_pixel  (req_above_pixel),
      .req_centre_pixel (req_centre_pixel),
      .req_below_pixel  (req_below_pixel),
      .req_line_end     (req_line_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_upper_left   (rsp_upper_left),
      .rsp_upper_right  (rsp_upper_right),
      .rsp_lower_left   (rsp_lower_left),
      .rsp_lower_right  (rsp_lower_right),
      .rsp_row_done     (rsp_row_done)
   );

   always #5 clock = ~clock;

   // Print one mismatch line (up to a limit) and count it
   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         flag_mismatch($sformatf("block %0d %s got %h want %h",
                                 blocks_checked, name, got, want));
      end
   endtask

   // Scale2x corners of one column from its five-pixel neighbourhood
   function automatic result_type corner_block(input pixel_type l, input pixel_type t,
                                               input pixel_type m, input pixel_type b,
                                               input pixel_type r, input logic done,
                                               input logic dbl);
      result_type blk;
      blk.upper_left  = (l == t && r != t && b != t) ? t : m;
      blk.upper_right = (r == t && l != t && b != t) ? t : m;
      blk.lower_left  = (l == b && r != b && t != b) ? b : m;
      blk.lower_right = (r == b && l != b && t != b) ? b : m;
      if (!dbl) begin
         blk.upper_right = '0;
         blk.lower_right = '0;
      end
      blk.row_done = done;
      return blk;
   endfunction

   // Monitor: check response transfers, track csr and request transfers
   always @(posedge clock) begin : monitor
      result_type want;
      pixel_type  left_nb;
      if (reset) begin
         req_taken  <= 1'b0;
         csr_taken  <= 1'b0;
         win_left   = '0;
         win_above  = '0;
         win_centre = '0;
         win_below  = '0;
         win_held   = 1'b0;
         width_mode = 1'b1;
      end else begin
         req_taken <= req_valid && req_ready;
         csr_taken <= csr_valid && csr_ready;

         // Compare a response transfer with the oldest predicted block
         if (rsp_valid && rsp_ready) begin
            if (expected_blocks.size() == 0) begin
               flag_mismatch($sformatf("unexpected block ul=%h ur=%h ll=%h lr=%h done=%b",
                                       rsp_upper_left, rsp_upper_right, rsp_lower_left,
                                       rsp_lower_right, rsp_row_done));
            end else begin
               want = expected_blocks.pop_front();
               check_field("upper_left", rsp_upper_left, want.upper_left);
               check_field("upper_right", rsp_upper_right, want.upper_right);
               check_field("lower_left", rsp_lower_left, want.lower_left);
               check_field("lower_right", rsp_lower_right, want.lower_right);
               check_field("row_done", 32'(rsp_row_done), 32'(want.row_done));
            end
            blocks_checked++;
         end

         if (csr_valid && csr_ready) begin
            width_mode = csr_double_width;
         end

         // Advance the window on a request transfer
         if (req_valid && req_ready) begin
            if (win_held) begin
               expected_blocks.push_back(corner_block(win_left, win_above, win_centre,
                                                      win_below, req_centre_pixel, 1'b0,
                                                      width_mode));
               left_nb = win_centre;
            end else begin
               left_nb = req_centre_pixel;
            end
            if (req_line_end) begin
               expected_blocks.push_back(corner_block(left_nb, req_above_pixel,
                                                      req_centre_pixel, req_below_pixel,
                                                      req_centre_pixel, 1'b1, width_mode));
               win_left   = '0;
               win_above  = '0;
               win_centre = '0;
               win_below  = '0;
               win_held   = 1'b0;
            end else begin
               win_left   = left_nb;
               win_above  = req_above_pixel;
               win_centre = req_centre_pixel;
               win_below  = req_below_pixel;
               win_held   = 1'b1;
            end
         end
      end
   end

   // Driver: present queued columns in bursts with random gaps
   always @(negedge clock) begin : driver
      column_type col;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold until the transfer completes
      end else if (gap_left > 0) begin
         req_valid <= 1'b0;
         gap_left--;
      end else if (pending_columns.size() > 0) begin
         col = pending_columns.pop_front();
         req_valid        <= 1'b1;
         req_above_pixel  <= col.above;
         req_centre_pixel <= col.centre;
         req_below_pixel  <= col.below;
         req_line_end     <= col.line_end;
         columns_sent++;
         if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         end else begin
            burst_left--;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Receiver: stall on one of four patterns, picked anew at random
   always @(negedge clock) begin : receiver
      logic ready_next;
      if (pattern_left == 0) begin
         stall_mode   = $urandom_range(0, 3);
         pattern_left = $urandom_range(20, 200);
      end else begin
         pattern_left--;
      end
      stall_tick++;
      case (stall_mode)
         0: begin
            ready_next = 1'b1;
         end
         1: begin
            ready_next = 1'($urandom_range(0, 1));
         end
         2: begin
            ready_next = (stall_tick % 4) != 3;
         end
         default: begin
            ready_next = ($urandom_range(0, 9) == 0);
         end
      endcase
      rsp_ready <= ready_next;
   end

   task automatic push_column(input pixel_type above, input pixel_type centre,
                              input pixel_type below, input logic last);
      column_type col;
      col.above    = above;
      col.centre   = centre;
      col.below    = below;
      col.line_end = last;
      pending_columns.push_back(col);
      if (last) begin
         lines_sent++;
      end
   endtask

   // Three-column line whose middle column sees left and right centres l and r
   task automatic push_probe_line(input pixel_type l, input pixel_type r);
      push_column(32'h0000_0011, l, 32'h0000_0022, 1'b0);
      push_column(32'h0000_0005, 32'h0000_0007, 32'h0000_0009, 1'b0);
      push_column(32'h0000_0033, r, 32'h0000_0044, 1'b1);
   endtask

   // Random line; a small palette makes the equality tests fire often
   task automatic push_random_line(input logic close_line);
      pixel_type   palette[3];
      int unsigned len;
      int unsigned pick;
      logic        wild;
      pixel_type   px[3];
      pick = $urandom_range(0, 99);
      len  = (pick < 80) ? $urandom_range(1, 8) : $urandom_range(9, 32);
      wild = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < 3; i++) begin
         case ($urandom_range(0, 3))
            0:       palette[i] = '0;
            1:       palette[i] = '1;
            default: palette[i] = pixel_type'($urandom);
         endcase
      end
      for (int c = 0; c < len; c++) begin
         for (int k = 0; k < 3; k++) begin
            px[k] = (wild || $urandom_range(0, 6) == 0) ? pixel_type'($urandom)
                                                       : palette[$urandom_range(0, 2)];
         end
         push_column(px[0], px[1], px[2], close_line && (c == len - 1));
      end
   endtask

   // Wait until every column is taken and every block has come back
   task automatic wait_drained();
      while (pending_columns.size() != 0 || req_valid || expected_blocks.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_width(input logic value);
      csr_valid        <= 1'b1;
      csr_double_width <= value;
      do @(negedge clock); while (!csr_taken);
      csr_valid <= 1'b0;
      csr_writes++;
      @(negedge clock);
   endtask

   // Stimulus: directed columns, then random phases under a set sequence of widths
   initial begin : stimulus
      logic        phase_widths[6];
      int unsigned phase_start;
      phase_widths = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Line one pixel wide at the extremes
      push_column('1, '0, '1, 1'b1);
      // Each corner fires in turn on the middle column
      push_probe_line(32'h0000_0005, 32'h0000_0008);
      push_probe_line(32'h0000_0008, 32'h0000_0005);
      push_probe_line(32'h0000_0009, 32'h0000_0008);
      push_probe_line(32'h0000_0008, 32'h0000_0009);
      // Above equals below blocks every corner
      push_column(32'h0000_0001, 32'h0000_0005, 32'h0000_0002, 1'b0);
      push_column(32'h0000_0005, 32'h0000_0007, 32'h0000_0005, 1'b0);
      push_column(32'h0000_0003, 32'h0000_0005, 32'h0000_0004, 1'b1);
      // Two-column line with all-ones and all-zeros pixels
      push_column('0, '1, '0, 1'b0);
      push_column('1, '0, '1, 1'b1);
      // Leave a column held across the width change
      push_column(32'h0000_00AA, 32'h0000_00AA, 32'h0000_00BB, 1'b0);
      wait_drained();
      write_width(1'b0);
      push_column(32'h0000_00CC, 32'h0000_00AA, 32'h0000_00AA, 1'b1);
      push_probe_line(32'h0000_0008, 32'h0000_0005);
      push_probe_line(32'h0000_0008, 32'h0000_0009);
      wait_drained();

      // Random phases; some end in the middle of a line
      foreach (phase_widths[p]) begin
         write_width(phase_widths[p]);
         phase_start = pending_columns.size() + columns_sent;
         while (pending_columns.size() + columns_sent - phase_start < PHASE_COLUMNS) begin
            push_random_line(1'b1);
         end
         if ($urandom_range(0, 1) == 1) begin
            push_random_line(1'b0);
         end
         wait_drained();
      end
      push_random_line(1'b1);
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d columns in %0d lines, checked %0d output blocks.",
               columns_sent, lines_sent, blocks_checked);
      $display("Width register written %0d times; %0d mismatches.",
               csr_writes, mismatch_count);
      if (mismatch_count == 0) begin
         $display("PASS pixel_art_edge_scaler_2x_top");
      end else begin
         $display("FAIL pixel_art_edge_scaler_2x_top");
      end
      $finish;
   end

   // Stop a run that hangs
   initial begin : watchdog
      #6ms;
      $display("Timeout with %0d columns queued, %0d blocks outstanding.",
               pending_columns.size(), expected_blocks.size());
      $display("FAIL pixel_art_edge_scaler_2x_top");
      $finish;
   end

endmodule
